>>> rtl/fscp_pkg.sv
// Package for the framed step-command pulser.
// Holds the shared types, codes and reset constants; depends on nothing.
`default_nettype none

package fscp_pkg;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 5;
  localparam int TICK_W  = 16;
  localparam int STAT_W  = 3;
  localparam int CIDX_W  = 8;

  // Default frame capacity in bytes.
  localparam int FRAME_MAX_DEF = 16;

  // Item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Frame bytes and commands.
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h5E;
  localparam logic [BYTE_W-1:0] CMD_LEFT  = 8'h30;
  localparam logic [BYTE_W-1:0] CMD_RIGHT = 8'h31;

  // Byte positions within a frame, and the shortest frame that holds a command.
  localparam logic [COUNT_W-1:0] POS_LEN     = 5'd2;
  localparam logic [COUNT_W-1:0] POS_STEPS_H = 5'd3;
  localparam logic [COUNT_W-1:0] POS_STEPS_L = 5'd4;
  localparam logic [COUNT_W-1:0] POS_CMD     = 5'd5;
  localparam logic [COUNT_W-1:0] MIN_FRAME   = 5'd6;

  // Byte status codes.
  localparam logic [STAT_W-1:0] ST_TICK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_STORED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOISE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd4;

  // Configuration register indexes and reset values.
  localparam logic [CIDX_W-1:0] REG_RAMP_START = 8'd0;
  localparam logic [CIDX_W-1:0] REG_RAMP_STEP  = 8'd1;
  localparam logic [TICK_W-1:0] RAMP_START_RST = 16'd20000;
  localparam logic [TICK_W-1:0] RAMP_STEP_RST  = 16'd50;

  // Ramp settings as seen by the pulse generator.
  typedef struct packed {
    logic [TICK_W-1:0] ramp_start;
    logic [TICK_W-1:0] ramp_step;
  } ramp_cfg_t;

  // Outcome of a completed frame, handed to the pulse generator.
  typedef struct packed {
    logic              done;
    logic              go;
    logic              left;
    logic [TICK_W-1:0] count;
  } frame_cmd_t;

  // Output levels of the pulse generator.
  typedef struct packed {
    logic enable;
    logic dir_left;
    logic pulse_high;
  } motion_t;

endpackage

`default_nettype wire

>>> rtl/fscp_if.sv
// Channel interfaces of the framed step-command pulser: input, result and
// configuration write. Depends on fscp_pkg for field widths.
`default_nettype none

interface fscp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [fscp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface fscp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        drive_enable;
  logic                        direction;
  logic                        step_level;
  logic                        moving;
  logic                        frame_done;
  logic [fscp_pkg::STAT_W-1:0] byte_status;

  modport source (output valid, output drive_enable, output direction, output step_level,
                  output moving, output frame_done, output byte_status, input ready);
  modport sink   (input valid, input drive_enable, input direction, input step_level,
                  input moving, input frame_done, input byte_status, output ready);
endinterface

interface fscp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fscp_pkg::CIDX_W-1:0] index;
  logic [fscp_pkg::TICK_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/framed_step_command_pulser.sv
// Framed step-command pulser, top level. Each input word is a received byte
// or one timer tick, and each gives exactly one result word. An accepted word
// sits in the input register, where the frame assembler and the step
// generator process it, and its result stands in the result register
// from the next edge on; result valid rises when the result register loads, and
// one word is taken every cycle as long as the result side keeps taking
// words. The result register holds while the result side stalls, and the
// input register then fills and stalls the input side. Ramp settings are to
// be written over the configuration channel only while the block is idle,
// which the block does not enforce; a write is taken in the cycle it is offered.
// Depends on fscp_pkg, fscp_if, fscp_cfg_regs, fscp_frame_rx and fscp_step_gen.
`default_nettype none

module framed_step_command_pulser #(
  parameter int FRAME_MAX = fscp_pkg::FRAME_MAX_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  fscp_in_if.sink   item,
  fscp_out_if.source result,
  fscp_cfg_if.sink  cfg
);
  import fscp_pkg::*;

  logic                 in_full;
  logic                 in_kind;
  logic [BYTE_W-1:0]    in_byte;
  logic                 out_full;
  logic                 done_q;
  logic [STAT_W-1:0]    status_q;
  logic                 fire;
  logic                 take;
  ramp_cfg_t            ramp;
  frame_cmd_t           cmd;
  motion_t              motion;
  logic [STAT_W-1:0]    status;

  // The processing step runs when a word is held and the result slot frees.
  assign fire       = in_full && (!out_full || result.ready);
  assign item.ready = !in_full || fire;
  assign take       = item.valid && item.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= take || (in_full && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_kind <= item.kind;
      in_byte <= item.rx_byte;
    end
  end

  fscp_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .ramp (ramp)
  );

  fscp_frame_rx #(
    .FRAME_MAX (FRAME_MAX)
  ) u_frame (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .kind          (in_kind),
    .rx_byte       (in_byte),
    .motion_active (motion.enable),
    .cmd           (cmd),
    .status        (status)
  );

  fscp_step_gen u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .kind   (in_kind),
    .cmd    (cmd),
    .ramp   (ramp),
    .motion (motion)
  );

  // Result register: status and frame flag here, levels in the step generator,
  // whose state only moves when a new result is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else begin
      out_full <= fire || (out_full && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      done_q   <= cmd.done && (in_kind == KIND_BYTE);
      status_q <= status;
    end
  end

  assign result.valid        = out_full;
  assign result.drive_enable = motion.enable;
  assign result.direction    = motion.dir_left;
  assign result.step_level   = motion.pulse_high;
  assign result.moving       = motion.enable;
  assign result.frame_done   = done_q;
  assign result.byte_status  = status_q;

  // A step pulse is only ever high during a move.
  assert property (@(posedge clk) disable iff (rst)
    motion.pulse_high |-> motion.enable)
    else $error("step pulse high outside a move");

  // A completed frame is always reported as a stored byte.
  assert property (@(posedge clk) disable iff (rst)
    (out_full && done_q) |-> (status_q == ST_STORED))
    else $error("frame completion on a byte that was not stored");

  // A byte dropped during a move leaves the move running.
  assert property (@(posedge clk) disable iff (rst)
    (out_full && status_q == ST_DROPPED) |-> motion.enable)
    else $error("dropped byte reported with no move active");

  // A stalled result keeps the motion levels it was produced with.
  assert property (@(posedge clk) disable iff (rst)
    (out_full && !result.ready) |=> $stable(motion))
    else $error("motion state changed under a stalled result");

endmodule

`default_nettype wire

>>> rtl/fscp_cfg_regs.sv
// Ramp configuration registers written over the configuration channel.
// Depends on fscp_pkg and fscp_if.
`default_nettype none

module fscp_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst,
  fscp_cfg_if.sink            cfg,
  output fscp_pkg::ramp_cfg_t ramp
);
  import fscp_pkg::*;

  // Writes are always taken; unknown indexes are ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp.ramp_start <= RAMP_START_RST;
      ramp.ramp_step  <= RAMP_STEP_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RAMP_START: ramp.ramp_start <= cfg.data;
        REG_RAMP_STEP:  ramp.ramp_step  <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/fscp_frame_rx.sv
// Frame assembler: collects bytes, checks sync, length and overflow, and
// reports a completed frame's command. Depends on fscp_pkg.
`default_nettype none

module fscp_frame_rx #(
  parameter int FRAME_MAX = fscp_pkg::FRAME_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          fire,
  input  wire logic                          kind,
  input  wire logic [fscp_pkg::BYTE_W-1:0]   rx_byte,
  input  wire logic                          motion_active,
  output fscp_pkg::frame_cmd_t               cmd,
  output logic      [fscp_pkg::STAT_W-1:0]   status
);
  import fscp_pkg::*;

  localparam logic [COUNT_W-1:0] FrameMaxW = COUNT_W'(FRAME_MAX);

  logic [COUNT_W-1:0] rx_count,     rx_count_next;
  logic [BYTE_W-1:0]  frame_length, frame_length_next;
  logic [BYTE_W-1:0]  steps_high,   steps_high_next;
  logic [BYTE_W-1:0]  steps_low,    steps_low_next;
  logic [BYTE_W-1:0]  command_byte, command_byte_next;
  logic [BYTE_W-1:0]  len_w, sh_w, sl_w, cmd_w;
  logic [COUNT_W-1:0] count_inc;
  logic               done_w;

  assign count_inc = rx_count + 1'b1;

  // Fields as they stand once the current byte is stored.
  always_comb begin
    len_w = frame_length;
    sh_w  = steps_high;
    sl_w  = steps_low;
    cmd_w = command_byte;
    case (rx_count)
      POS_LEN:     len_w = rx_byte;
      POS_STEPS_H: sh_w  = rx_byte;
      POS_STEPS_L: sl_w  = rx_byte;
      POS_CMD:     cmd_w = rx_byte;
      default: ;
    endcase
  end

  // Command decode for a frame that this byte may complete.
  assign cmd.count = {sh_w, sl_w};
  assign cmd.left  = (cmd_w == CMD_LEFT);
  assign cmd.go    = ((cmd_w == CMD_LEFT) || (cmd_w == CMD_RIGHT)) && (cmd.count != '0);
  assign cmd.done  = done_w;

  // Byte classification and frame state update.
  always_comb begin
    rx_count_next     = rx_count;
    frame_length_next = frame_length;
    steps_high_next   = steps_high;
    steps_low_next    = steps_low;
    command_byte_next = command_byte;
    done_w            = 1'b0;
    status            = ST_TICK;
    if (kind == KIND_BYTE) begin
      if (motion_active) begin
        status = ST_DROPPED;
      end else if (rx_count == '0 && rx_byte != SYNC_BYTE) begin
        status = ST_NOISE;
      end else if (rx_count >= FrameMaxW) begin
        status            = ST_OVERFLOW;
        rx_count_next     = '0;
        frame_length_next = '0;
        steps_high_next   = '0;
        steps_low_next    = '0;
        command_byte_next = '0;
      end else begin
        status            = ST_STORED;
        rx_count_next     = count_inc;
        frame_length_next = len_w;
        steps_high_next   = sh_w;
        steps_low_next    = sl_w;
        command_byte_next = cmd_w;
        if (count_inc >= MIN_FRAME && {3'b000, count_inc} == len_w) begin
          done_w            = 1'b1;
          rx_count_next     = '0;
          frame_length_next = '0;
          steps_high_next   = '0;
          steps_low_next    = '0;
          command_byte_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count     <= '0;
      frame_length <= '0;
      steps_high   <= '0;
      steps_low    <= '0;
      command_byte <= '0;
    end else if (fire) begin
      rx_count     <= rx_count_next;
      frame_length <= frame_length_next;
      steps_high   <= steps_high_next;
      steps_low    <= steps_low_next;
      command_byte <= command_byte_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fscp_step_gen.sv
// Step pulse generator: counts ticks into high and low half-periods and
// counts down the pulses of a move. Depends on fscp_pkg.
`default_nettype none

module fscp_step_gen (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire logic                 kind,
  input  wire fscp_pkg::frame_cmd_t cmd,
  input  wire fscp_pkg::ramp_cfg_t  ramp,
  output fscp_pkg::motion_t         motion
);
  import fscp_pkg::*;

  logic              motion_active, motion_active_next;
  logic              dir_left,      dir_left_next;
  logic              pulse_high,    pulse_high_next;
  logic [TICK_W-1:0] pulses_left,   pulses_left_next;
  logic [TICK_W-1:0] tick_count,    tick_count_next;
  logic [TICK_W-1:0] half_period,   half_period_next;
  logic [TICK_W-1:0] tick_inc, pulses_dec, ramped_hp;
  logic [TICK_W-1:0] ramp_diff;

  assign tick_inc   = tick_count + 1'b1;
  assign pulses_dec = pulses_left - 1'b1;
  assign ramp_diff  = ramp.ramp_start - ramp.ramp_step;

  // Half-period of a move: the larger of start minus step and step, at least one.
  always_comb begin
    ramped_hp = ramp.ramp_step;
    if (ramp.ramp_start > ramp.ramp_step && ramp_diff > ramp.ramp_step) begin
      ramped_hp = ramp_diff;
    end
    if (ramped_hp == '0) begin
      ramped_hp = TICK_W'(1);
    end
  end

  // Tick counting, pulse toggling, and moves started or stopped by a frame.
  always_comb begin
    motion_active_next = motion_active;
    dir_left_next      = dir_left;
    pulse_high_next    = pulse_high;
    pulses_left_next   = pulses_left;
    tick_count_next    = tick_count;
    half_period_next   = half_period;
    if (kind == KIND_TICK) begin
      if (motion_active) begin
        tick_count_next = tick_inc;
        if (tick_inc >= half_period) begin
          tick_count_next = '0;
          if (pulse_high) begin
            pulse_high_next = 1'b0;
          end else if (pulses_dec == '0) begin
            motion_active_next = 1'b0;
            pulses_left_next   = '0;
            half_period_next   = ramp.ramp_start;
          end else begin
            pulses_left_next = pulses_dec;
            pulse_high_next  = 1'b1;
          end
        end
      end
    end else if (cmd.done) begin
      tick_count_next = '0;
      if (cmd.go) begin
        motion_active_next = 1'b1;
        dir_left_next      = cmd.left;
        pulse_high_next    = 1'b1;
        pulses_left_next   = cmd.count;
        half_period_next   = ramped_hp;
      end else begin
        motion_active_next = 1'b0;
        pulse_high_next    = 1'b0;
        pulses_left_next   = '0;
        half_period_next   = ramp.ramp_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_active <= 1'b0;
      dir_left      <= 1'b0;
      pulse_high    <= 1'b0;
      pulses_left   <= '0;
      tick_count    <= '0;
      half_period   <= RAMP_START_RST;
    end else if (fire) begin
      motion_active <= motion_active_next;
      dir_left      <= dir_left_next;
      pulse_high    <= pulse_high_next;
      pulses_left   <= pulses_left_next;
      tick_count    <= tick_count_next;
      half_period   <= half_period_next;
    end
  end

  assign motion.enable     = motion_active;
  assign motion.dir_left   = dir_left;
  assign motion.pulse_high = pulse_high;

endmodule

`default_nettype wire
